/* rtl/core/wuf_pkg.sv */
// Shared types and widths of the upwind wave flux pipeline.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package wuf_pkg;

  localparam int DATA_W   = 32;   // width of every state, normal and flux field
  localparam int DIM_DEF  = 3;    // default number of active vector components
  localparam int FRAC_DEF = 16;   // default fraction bits of the fixed-point format
  localparam int SUM_W    = 33;   // sum or difference of two fields
  localparam int DOT_W    = 67;   // dot product of three 33 x 32 bit products
  localparam int RAD_W    = 64;   // squared normal length
  localparam int ROOT_W   = 32;   // normal length
  localparam int INNER_W  = 68;   // pressure-sum term plus jump dot product
  localparam int NUM_W    = 100;  // inner term times a normal component
  localparam int MAG_W    = 102;  // dividend magnitude handed to the divider
  localparam int QUOT_W   = 32;   // quotient bits resolved by the divider

  typedef struct packed {
    logic signed [DATA_W-1:0] left_flow_x;
    logic signed [DATA_W-1:0] left_flow_y;
    logic signed [DATA_W-1:0] left_flow_z;
    logic signed [DATA_W-1:0] left_pressure;
    logic signed [DATA_W-1:0] right_flow_x;
    logic signed [DATA_W-1:0] right_flow_y;
    logic signed [DATA_W-1:0] right_flow_z;
    logic signed [DATA_W-1:0] right_pressure;
    logic signed [DATA_W-1:0] normal_x;
    logic signed [DATA_W-1:0] normal_y;
    logic signed [DATA_W-1:0] normal_z;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] flux_x;
    logic signed [DATA_W-1:0] flux_y;
    logic signed [DATA_W-1:0] flux_z;
    logic signed [DATA_W-1:0] flux_pressure;
    logic                     zero_normal;
  } out_t;

  // Geometry terms that ride alongside the square root.
  typedef struct packed {
    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT_W-1:0]  sdot;
    logic signed [SUM_W-1:0]  psum;
    logic signed [SUM_W-1:0]  pdiff;
    logic [2:0][DATA_W-1:0]   nrm;
    logic                     zero;
  } geo_t;

  // Terms that ride alongside the divider.
  typedef struct packed {
    logic              zero;
    logic [DATA_W-1:0] pres;
    logic [2:0]        neg;
  } side_t;

endpackage

/* rtl/core/wuf_front.sv */
// Front end: component masking, jumps, averages, products and dot products.
// Depends on wuf_pkg. Three register stages.
`timescale 1ns / 1ps

module wuf_front import wuf_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  in_t              item,
  output logic             out_valid,
  output logic [RAD_W-1:0] norm2,
  output geo_t             geo
);

  logic signed [DATA_W-1:0] lq [3];
  logic signed [DATA_W-1:0] rq [3];
  logic signed [DATA_W-1:0] nrm_next [3];

  always_comb begin
    lq[0] = item.left_flow_x;
    lq[1] = item.left_flow_y;
    lq[2] = item.left_flow_z;
    rq[0] = item.right_flow_x;
    rq[1] = item.right_flow_y;
    rq[2] = item.right_flow_z;
    nrm_next[0] = item.normal_x;
    nrm_next[1] = (DIM > 1) ? item.normal_y : '0;
    nrm_next[2] = (DIM > 2) ? item.normal_z : '0;
  end

  // Stage 1: sums and differences.
  logic                     v1;
  logic signed [DATA_W-1:0] nrm1 [3];
  logic signed [SUM_W-1:0]  dq1 [3];
  logic signed [SUM_W-1:0]  sq1 [3];
  logic signed [SUM_W-1:0]  psum1;
  logic signed [SUM_W-1:0]  pdiff1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        nrm1[j] <= nrm_next[j];
        dq1[j]  <= SUM_W'(lq[j]) - SUM_W'(rq[j]);
        sq1[j]  <= SUM_W'(lq[j]) + SUM_W'(rq[j]);
      end
      psum1  <= SUM_W'(item.left_pressure) + SUM_W'(item.right_pressure);
      pdiff1 <= SUM_W'(item.left_pressure) - SUM_W'(item.right_pressure);
    end
  end

  // Stage 2: products. The sum of two most negative flows times the most
  // negative normal reaches 2^63, so the sum products carry one more bit.
  logic signed [RAD_W-1:0]   sqr_c [3];
  logic signed [DOT_W-3:0]   dp_c [3];
  logic signed [DOT_W-2:0]   sp_c [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sqr_c[j] = nrm1[j] * nrm1[j];
      dp_c[j]  = dq1[j] * nrm1[j];
      sp_c[j]  = sq1[j] * nrm1[j];
    end
  end

  logic                     v2;
  logic [RAD_W-1:0]         sqr2 [3];
  logic signed [DOT_W-3:0]  dp2 [3];
  logic signed [DOT_W-2:0]  sp2 [3];
  logic signed [DATA_W-1:0] nrm2 [3];
  logic signed [SUM_W-1:0]  psum2;
  logic signed [SUM_W-1:0]  pdiff2;
  logic                     zero2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sqr2[j] <= sqr_c[j];
        dp2[j]  <= dp_c[j];
        sp2[j]  <= sp_c[j];
        nrm2[j] <= nrm1[j];
      end
      psum2  <= psum1;
      pdiff2 <= pdiff1;
      zero2  <= (nrm1[0] == '0) && (nrm1[1] == '0) && (nrm1[2] == '0);
    end
  end

  // Stage 3: reductions.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm2     <= sqr2[0] + sqr2[1] + sqr2[2];
      geo.dot   <= DOT_W'(dp2[0]) + DOT_W'(dp2[1]) + DOT_W'(dp2[2]);
      geo.sdot  <= DOT_W'(sp2[0]) + DOT_W'(sp2[1]) + DOT_W'(sp2[2]);
      geo.psum  <= psum2;
      geo.pdiff <= pdiff2;
      geo.nrm   <= {nrm2[2], nrm2[1], nrm2[0]};
      geo.zero  <= zero2;
    end
  end

endmodule

/* rtl/core/wuf_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on wuf_pkg.
`timescale 1ns / 1ps

module wuf_isqrt import wuf_pkg::*; #(
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [SW-1:0]     side_out
);

  localparam int NST = ROOT_W;

  logic [RAD_W-1:0] rem_q [NST];
  logic [RAD_W-1:0] res_q [NST];
  logic [SW-1:0]    sd_q  [NST];
  logic [NST-1:0]   v_q;

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (NST - 1 - k));

    logic [RAD_W-1:0] rem_i;
    logic [RAD_W-1:0] res_i;
    logic [SW-1:0]    sd_i;
    logic             v_i;
    logic [RAD_W-1:0] trial;

    if (k == 0) begin : g_head
      assign rem_i = rad;
      assign res_i = '0;
      assign sd_i  = side_in;
      assign v_i   = in_valid;
    end else begin : g_body
      assign rem_i = rem_q[k-1];
      assign res_i = res_q[k-1];
      assign sd_i  = sd_q[k-1];
      assign v_i   = v_q[k-1];
    end

    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_q[k] <= sd_i;
        if (rem_i >= trial) begin
          rem_q[k] <= rem_i - trial;
          res_q[k] <= (res_i >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_i;
          res_q[k] <= res_i >> 1;
        end
      end
    end
  end

  assign out_valid = v_q[NST-1];
  assign root      = res_q[NST-1][ROOT_W-1:0];
  assign side_out  = sd_q[NST-1];

endmodule

/* rtl/core/wuf_mid.sv */
// Middle section: inner term, flow numerators, rounded pressure flux, divisor.
// Depends on wuf_pkg. Six register stages.
`timescale 1ns / 1ps

module wuf_mid import wuf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF,
  parameter int DEN_W     = ROOT_W + FRAC_DEF + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] nlen,
  input  geo_t              geo,
  output logic              out_valid,
  output logic [MAG_W-1:0]  mag [3],
  output logic [DEN_W-1:0]  den,
  output side_t             side
);

  localparam int LO_W  = INNER_W / 2;
  localparam int PR_W  = INNER_W + 1;
  localparam int PA_W  = SUM_W + ROOT_W + 1;
  localparam logic signed [PR_W-1:0] P_HALF = PR_W'(1) <<< FRAC_BITS;
  localparam logic signed [PR_W-1:0] P_MAX  = PR_W'(32'h7fff_ffff);
  localparam logic signed [PR_W-1:0] P_MIN  = -(PR_W'(1) <<< (DATA_W - 1));

  function automatic logic [DATA_W-1:0] sat32(input logic signed [PR_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > P_MAX) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < P_MIN) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  logic [6:1] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
    end
  end

  // Stage 1: pressure terms scaled by the normal length.
  logic signed [PA_W-1:0]   pa_c, pp_c;
  logic signed [PA_W-1:0]   pa1, pp1;
  logic signed [DOT_W-1:0]  dot1, sdot1;
  logic [2:0][DATA_W-1:0]   nrm1;
  logic [ROOT_W-1:0]        nlen1;
  logic                     zero1;

  always_comb begin
    pa_c = geo.psum  * $signed({1'b0, nlen});
    pp_c = geo.pdiff * $signed({1'b0, nlen});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1   <= pa_c;
      pp1   <= pp_c;
      dot1  <= geo.dot;
      sdot1 <= geo.sdot;
      nrm1  <= geo.nrm;
      nlen1 <= nlen;
      zero1 <= geo.zero;
    end
  end

  // Stage 2: inner term and pressure numerator.
  logic signed [INNER_W-1:0] inner2, pnum2;
  logic [2:0][DATA_W-1:0]    nrm2;
  logic [ROOT_W-1:0]         nlen2;
  logic                      zero2;

  always_ff @(posedge clk) begin
    if (en) begin
      inner2 <= INNER_W'(pa1) + INNER_W'(dot1);
      pnum2  <= INNER_W'(sdot1) + INNER_W'(pp1);
      nrm2   <= nrm1;
      nlen2  <= nlen1;
      zero2  <= zero1;
    end
  end

  // Stage 3: split products of the inner term with each normal component.
  logic signed [LO_W+DATA_W:0]   lo_c [3];
  logic signed [LO_W+DATA_W-1:0] hi_c [3];
  logic signed [PR_W-1:0]        pr_sum, pr_sh;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_c[j] = $signed({1'b0, inner2[LO_W-1:0]}) * $signed(nrm2[j]);
      hi_c[j] = $signed(inner2[INNER_W-1:LO_W]) * $signed(nrm2[j]);
    end
    pr_sum = PR_W'(pnum2) + P_HALF;
    pr_sh  = pr_sum >>> (FRAC_BITS + 1);
  end

  logic signed [LO_W+DATA_W:0]   lo3 [3];
  logic signed [LO_W+DATA_W-1:0] hi3 [3];
  logic [DATA_W-1:0]             pres3;
  logic [ROOT_W-1:0]             nlen3;
  logic                          zero3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo3[j] <= lo_c[j];
        hi3[j] <= hi_c[j];
      end
      pres3 <= sat32(pr_sh);
      nlen3 <= nlen2;
      zero3 <= zero2;
    end
  end

  // Stage 4: recombine partial products; divisor and rounding offset.
  logic signed [NUM_W-1:0] num_c [3];
  logic signed [NUM_W-1:0] num4 [3];
  logic [DEN_W-1:0]        den4, half4;
  logic [DATA_W-1:0]       pres4;
  logic                    zero4;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num_c[j] = $signed({hi3[j], {LO_W{1'b0}}}) + lo3[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        num4[j] <= num_c[j];
      end
      den4  <= DEN_W'(nlen3) << (FRAC_BITS + 1);
      half4 <= DEN_W'(nlen3) << FRAC_BITS;
      pres4 <= pres3;
      zero4 <= zero3;
    end
  end

  // Stage 5: add half a divisor for round to nearest.
  logic [MAG_W-1:0]  nn5 [3];
  logic [DEN_W-1:0]  den5;
  logic [DATA_W-1:0] pres5;
  logic              zero5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        nn5[j] <= MAG_W'(num4[j]) + MAG_W'(half4);
      end
      den5  <= den4;
      pres5 <= pres4;
      zero5 <= zero4;
    end
  end

  // Stage 6: floor of a negative value becomes a ceiling on its magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag[j]      <= nn5[j][MAG_W-1] ? (~nn5[j] + MAG_W'(den5)) : nn5[j];
        side.neg[j] <= nn5[j][MAG_W-1];
      end
      den       <= den5;
      side.pres <= pres5;
      side.zero <= zero5;
    end
  end

  assign out_valid = v[6];

endmodule

/* rtl/core/wuf_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, one bit per stage.
// Depends on wuf_pkg. One range-check stage plus QUOT_W quotient stages.
`timescale 1ns / 1ps

module wuf_div import wuf_pkg::*; #(
  parameter int DEN_W = ROOT_W + FRAC_DEF + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  mag [3],
  input  logic [DEN_W-1:0]  den,
  input  side_t             side_in,
  output logic              out_valid,
  output logic [QUOT_W-1:0] quot [3],
  output logic [2:0]        ovf,
  output side_t             side_out
);

  localparam int REM_W = DEN_W + QUOT_W;

  // Range check: a quotient of 2^QUOT_W or more only needs to be flagged.
  logic [MAG_W-1:0] lim;
  assign lim = MAG_W'({den, {QUOT_W{1'b0}}});

  logic             v0;
  logic [REM_W-1:0] rem0 [3];
  logic [2:0]       ovf0;
  logic [DEN_W-1:0] den0;
  side_t            side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        rem0[j] <= mag[j][REM_W-1:0];
        ovf0[j] <= mag[j] >= lim;
      end
      den0  <= den;
      side0 <= side_in;
    end
  end

  logic [REM_W-1:0]  rem_q [QUOT_W][3];
  logic [QUOT_W-1:0] q_q   [QUOT_W][3];
  logic [2:0]        ovf_q [QUOT_W];
  logic [DEN_W-1:0]  den_q [QUOT_W];
  side_t             sd_q  [QUOT_W];
  logic [QUOT_W-1:0] v_q;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_st
    logic [REM_W-1:0]  rem_i [3];
    logic [QUOT_W-1:0] q_i [3];
    logic [2:0]        ovf_i;
    logic [DEN_W-1:0]  den_i;
    side_t             sd_i;
    logic              v_i;
    logic [REM_W-1:0]  sub;

    if (k == 0) begin : g_head
      for (genvar j = 0; j < 3; j++) begin : g_ln
        assign rem_i[j] = rem0[j];
        assign q_i[j]   = '0;
      end
      assign ovf_i = ovf0;
      assign den_i = den0;
      assign sd_i  = side0;
      assign v_i   = v0;
    end else begin : g_body
      for (genvar j = 0; j < 3; j++) begin : g_ln
        assign rem_i[j] = rem_q[k-1][j];
        assign q_i[j]   = q_q[k-1][j];
      end
      assign ovf_i = ovf_q[k-1];
      assign den_i = den_q[k-1];
      assign sd_i  = sd_q[k-1];
      assign v_i   = v_q[k-1];
    end

    assign sub = REM_W'(den_i) << (QUOT_W - 1 - k);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          if (rem_i[j] >= sub) begin
            rem_q[k][j] <= rem_i[j] - sub;
            q_q[k][j]   <= {q_i[j][QUOT_W-2:0], 1'b1};
          end else begin
            rem_q[k][j] <= rem_i[j];
            q_q[k][j]   <= {q_i[j][QUOT_W-2:0], 1'b0};
          end
        end
        ovf_q[k] <= ovf_i;
        den_q[k] <= den_i;
        sd_q[k]  <= sd_i;
      end
    end
  end

  assign out_valid = v_q[QUOT_W-1];
  assign ovf       = ovf_q[QUOT_W-1];
  assign side_out  = sd_q[QUOT_W-1];

  for (genvar j = 0; j < 3; j++) begin : g_out
    assign quot[j] = q_q[QUOT_W-1][j];
  end

endmodule

/* rtl/core/wave_upwind_flux.sv */
// Top level of the upwind numerical flux for the first-order acoustic wave system.
// Depends on wuf_pkg, wuf_front, wuf_isqrt, wuf_mid and wuf_div.
`timescale 1ns / 1ps

// The block takes one quadrature point per transaction (left and right flow and
// pressure, plus a face normal of any length, all signed fixed point with
// FRAC_BITS fraction bits) and returns one flux transaction for it. It accepts a
// new point every clock cycle while item_ready is high. Each point passes in turn
// through products and dot products, the square root of the squared normal
// length (one root bit per stage), the forming of the numerators and the rounded
// pressure flux, the divider that divides each flow numerator by the normal
// length (one quotient bit per stage)
// and one output register. All flux parts are rounded to nearest, ties toward
// plus infinity, and saturated to 32 bits. A normal whose active components are
// all zero yields an all-zero flux with zero_normal set. Only the first DIM
// components take part; the flux fields of the unused components read zero.
// When the consumer stalls with a result waiting, the whole pipeline still
// advances, and keeps accepting points, until a result reaches its last stage.

module wave_upwind_flux import wuf_pkg::*; #(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  in_t  item,
  output logic flux_valid,
  input  logic flux_ready,
  output out_t flux
);

  // Divisor 2 * 2^FRAC_BITS * |n|.
  localparam int DEN_W = ROOT_W + FRAC_BITS + 1;
  localparam int GEO_W = $bits(geo_t);

  // Saturate a quotient magnitude to the signed range, with its sign applied.
  function automatic logic [DATA_W-1:0] flux_sat(input logic [QUOT_W-1:0] q,
                                                 input logic ovf_in,
                                                 input logic neg);
    logic [DATA_W-1:0] r;
    if (!neg) begin
      r = (ovf_in || q[QUOT_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}} : q;
    end else if (ovf_in || (q[QUOT_W-1] && (q[QUOT_W-2:0] != '0))) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = ~q + 1'b1;
    end
    return r;
  endfunction

  // One enable for the whole pipeline. It drops only when the output register
  // holds a result that is not being taken and the last stage has another one
  // ready to move into it; the pipeline keeps advancing otherwise.
  logic en;
  logic d_valid;

  assign en         = !(flux_valid && !flux_ready && d_valid);
  assign item_ready = en;

  logic             f_valid;
  logic [RAD_W-1:0] f_norm2;
  geo_t             f_geo;

  wuf_front #(
    .DIM (DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item_valid),
    .item      (item),
    .out_valid (f_valid),
    .norm2     (f_norm2),
    .geo       (f_geo)
  );

  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  logic [GEO_W-1:0]  s_geo_bits;

  wuf_isqrt #(
    .SW (GEO_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .rad       (f_norm2),
    .side_in   (f_geo),
    .out_valid (s_valid),
    .root      (s_root),
    .side_out  (s_geo_bits)
  );

  logic             m_valid;
  logic [MAG_W-1:0] m_mag [3];
  logic [DEN_W-1:0] m_den;
  side_t            m_side;

  wuf_mid #(
    .FRAC_BITS (FRAC_BITS),
    .DEN_W     (DEN_W)
  ) u_mid (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .nlen      (s_root),
    .geo       (geo_t'(s_geo_bits)),
    .out_valid (m_valid),
    .mag       (m_mag),
    .den       (m_den),
    .side      (m_side)
  );

  logic [QUOT_W-1:0] d_quot [3];
  logic [2:0]        d_ovf;
  side_t             d_side;

  wuf_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_valid),
    .mag       (m_mag),
    .den       (m_den),
    .side_in   (m_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .ovf       (d_ovf),
    .side_out  (d_side)
  );

  // Output register. With a zero normal the divisor is zero and the quotients
  // mean nothing, so every flux field is forced to zero.
  logic [DATA_W-1:0] fx, fy, fz;

  always_comb begin
    fx = flux_sat(d_quot[0], d_ovf[0], d_side.neg[0]);
    fy = flux_sat(d_quot[1], d_ovf[1], d_side.neg[1]);
    fz = flux_sat(d_quot[2], d_ovf[2], d_side.neg[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flux_valid <= 1'b0;
    end else if (!flux_valid || flux_ready) begin
      flux_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!flux_valid || flux_ready) begin
      flux.flux_x        <= d_side.zero ? '0 : fx;
      flux.flux_y        <= d_side.zero ? '0 : fy;
      flux.flux_z        <= d_side.zero ? '0 : fz;
      flux.flux_pressure <= d_side.zero ? '0 : d_side.pres;
      flux.zero_normal   <= d_side.zero;
    end
  end

endmodule

/* rtl/core/wuf_check.sv */
// Port-level checker for wave_upwind_flux and the bind that attaches it.
// Depends on wuf_pkg.
`timescale 1ns / 1ps

module wuf_check import wuf_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input in_t  item,
  input logic flux_valid,
  input logic flux_ready,
  input out_t flux
);

  // A point that is not taken stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("point transaction withdrawn or changed before it was taken");

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    flux_valid && !flux_ready |=> flux_valid)
    else $error("flux transaction withdrawn before it was taken");

  // Nothing comes out in the cycle right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !flux_valid)
    else $error("flux transaction offered straight after reset");

  // A zero normal gives an all-zero flux.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    flux_valid && flux.zero_normal |->
      flux.flux_x == '0 && flux.flux_y == '0 && flux.flux_z == '0 &&
      flux.flux_pressure == '0)
    else $error("zero normal with nonzero flux");

  // Components beyond the active dimension read zero.
  a_unused: assert property (@(posedge clk) disable iff (rst)
    flux_valid |-> (DIM > 2 || flux.flux_z == '0) && (DIM > 1 || flux.flux_y == '0))
    else $error("flux of an unused component is nonzero");

endmodule

bind wave_upwind_flux wuf_check #(.DIM(DIM)) u_check (.*);

/* bench/tb_wave_upwind_flux.sv */
// Self-checking testbench of the upwind wave flux pipeline (wave_upwind_flux).
// Depends on wuf_pkg and the block's RTL; it predicts each flux from its own model.
`timescale 1ns / 1ps

module tb_wave_upwind_flux;
  import wuf_pkg::*;

  localparam int DIM       = DIM_DEF;
  localparam int FRAC_BITS = FRAC_DEF;
  localparam int LATENCY   = 75;
  localparam longint CYCLE_LIMIT = 400000;

  // Idle modes of the two sides.
  typedef enum logic [1:0] {
    IDLE_SEND_LIGHT,  // sender idles 16 percent of the time, receiver 58 percent
    IDLE_SEND_HEAVY,  // sender idles 58 percent of the time, receiver 16 percent
    IDLE_NONE
  } idle_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_t  item = '0;
  logic flux_valid;
  logic flux_ready = 1'b0;
  out_t flux;

  // The stimulus process fills the pending-point queue; the driver drains it.
  in_t  pending_points[$];
  // Expected flux transactions, oldest first.
  out_t flux_expected[$];

  idle_mode_e idle_mode = IDLE_SEND_LIGHT;
  int  hold_off_cycles = 0;     // receiver holds off while this is nonzero
  bit  stimulus_done = 1'b0;
  int  mismatch_count = 0;
  longint cycle_count = 0;

  wave_upwind_flux #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .flux_valid (flux_valid),
    .flux_ready (flux_ready),
    .flux       (flux)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounds num / den to nearest with ties toward plus infinity (den > 0),
  // then saturates to the signed 32-bit range.
  function automatic logic signed [31:0] round_sat(logic signed [159:0] num,
                                                   logic signed [159:0] den);
    logic signed [159:0] n2;
    logic signed [159:0] q;
    n2 = num * 2 + den;
    if (n2 >= 0) begin
      q = n2 / (den * 2);
    end else begin
      q = -((-n2 + den * 2 - 1) / (den * 2));
    end
    if (q > 160'sd2147483647) return 32'sh7fffffff;
    if (q < -160'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  // Predicts the flux transaction for one quadrature point.
  function automatic out_t upwind_flux(in_t pt);
    logic signed [159:0] ql[3], qr[3], nv[3];
    logic signed [159:0] pl, pr, jump_dot, mean_dot, inner, nlen, scale;
    logic [63:0] norm2;
    logic [63:0] root, trial;
    logic signed [31:0] parts[3];
    out_t r;
    ql = '{pt.left_flow_x, pt.left_flow_y, pt.left_flow_z};
    qr = '{pt.right_flow_x, pt.right_flow_y, pt.right_flow_z};
    nv = '{pt.normal_x, pt.normal_y, pt.normal_z};
    pl = pt.left_pressure;
    pr = pt.right_pressure;
    scale = 160'sd1 <<< FRAC_BITS;
    norm2 = '0;
    jump_dot = '0;
    mean_dot = '0;
    for (int j = 0; j < DIM; j++) begin
      norm2 += 64'(nv[j] * nv[j]);
      jump_dot += (ql[j] - qr[j]) * nv[j];
      mean_dot += (ql[j] + qr[j]) * nv[j];
    end
    r = '0;
    if (norm2 == 0) begin
      r.zero_normal = 1'b1;
      return r;
    end
    // Bitwise integer square root, rounded down.
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= norm2) root = trial;
    end
    nlen = $signed({96'd0, root});
    inner = (pl + pr) * nlen + jump_dot;
    parts = '{default: '0};
    for (int j = 0; j < DIM; j++) begin
      parts[j] = round_sat(inner * nv[j], 2 * scale * nlen);
    end
    r.flux_x = parts[0];
    r.flux_y = parts[1];
    r.flux_z = parts[2];
    r.flux_pressure = round_sat(mean_dot + (pl - pr) * nlen, 2 * scale);
    return r;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_point();
    in_t p;
    p.left_flow_x    = rand_field();
    p.left_flow_y    = rand_field();
    p.left_flow_z    = rand_field();
    p.left_pressure  = rand_field();
    p.right_flow_x   = rand_field();
    p.right_flow_y   = rand_field();
    p.right_flow_z   = rand_field();
    p.right_pressure = rand_field();
    p.normal_x       = rand_field();
    p.normal_y       = rand_field();
    p.normal_z       = rand_field();
    // Some points get an all-zero normal so the zero-normal case recurs.
    if ($urandom_range(0, 19) == 0) begin
      p.normal_x = '0;
      p.normal_y = '0;
      p.normal_z = '0;
    end
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("flux mismatch %s: got %h expected %h at cycle %0d",
             field, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || item_valid || flux_expected.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offers queued points, holding each until it is accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (!item_valid || item_ready) begin
        if (pending_points.size() != 0 &&
            !(idle_mode == IDLE_SEND_LIGHT && $urandom_range(0, 99) < 16) &&
            !(idle_mode == IDLE_SEND_HEAVY && $urandom_range(0, 99) < 58)) begin
          item <= pending_points[0];
          flux_expected.push_back(upwind_flux(pending_points[0]));
          void'(pending_points.pop_front());
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random idling, plus a counted long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      flux_ready <= 1'b0;
    end else if (idle_mode == IDLE_SEND_LIGHT) begin
      flux_ready <= $urandom_range(0, 99) >= 58;
    end else if (idle_mode == IDLE_SEND_HEAVY) begin
      flux_ready <= $urandom_range(0, 99) >= 16;
    end else begin
      flux_ready <= 1'b1;
    end
  end

  // Monitor: compares each accepted flux transaction with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && flux_valid && flux_ready) begin
      if (flux_expected.size() == 0) begin
        report_mismatch("unexpected transaction", flux.flux_x, 32'h0);
      end else begin
        want = flux_expected.pop_front();
        if (flux.flux_x !== want.flux_x) report_mismatch("flux_x", flux.flux_x, want.flux_x);
        if (flux.flux_y !== want.flux_y) report_mismatch("flux_y", flux.flux_y, want.flux_y);
        if (flux.flux_z !== want.flux_z) report_mismatch("flux_z", flux.flux_z, want.flux_z);
        if (flux.flux_pressure !== want.flux_pressure)
          report_mismatch("flux_pressure", flux.flux_pressure, want.flux_pressure);
        if (flux.zero_normal !== want.zero_normal)
          report_mismatch("zero_normal", 32'(flux.zero_normal), 32'(want.zero_normal));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    in_t p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed points: field extremes, zero normal, unit normals, saturation.
    p = '0;
    p.normal_x = 32'h00010000;
    pending_points.push_back(p);                 // all-zero state, unit normal
    p = '0;
    pending_points.push_back(p);                 // zero normal
    p = '{default: 32'h7fffffff};
    pending_points.push_back(p);                 // all maxima
    p = '{default: 32'h80000000};
    pending_points.push_back(p);                 // all minima
    p = '{default: 32'h7fffffff};
    p.right_flow_x = 32'h80000000;
    p.right_flow_y = 32'h80000000;
    p.right_flow_z = 32'h80000000;
    p.right_pressure = 32'h80000000;
    pending_points.push_back(p);                 // largest jumps, saturating
    p = '{default: 32'hffffffff};
    pending_points.push_back(p);                 // all ones
    p = '0;
    p.left_pressure = 32'h00010000;
    p.normal_y = 32'h00000001;
    pending_points.push_back(p);                 // tiny normal, rounding ties
    p = '0;
    p.left_flow_z = 32'h00020000;
    p.normal_z = 32'hffff0000;
    pending_points.push_back(p);                 // negative normal on z only
    p = '0;
    p.left_flow_x = 32'h00000001;
    p.right_flow_x = 32'hffffffff;
    p.normal_x = 32'h00000003;
    p.normal_y = 32'h00000004;
    pending_points.push_back(p);                 // exact root, results round to zero
    for (int k = 0; k < 8; k++) pending_points.push_back(rand_point());
    wait_drained();

    // Random points under the three idling modes.
    for (int m = 0; m < 3; m++) begin
      idle_mode = idle_mode_e'(m);
      for (int k = 0; k < 400; k++) pending_points.push_back(rand_point());
      if (m == 2) begin
        // Long hold-off on the receiver while points keep coming, so the
        // pipeline fills and stops accepting.
        hold_off_cycles = 300;
      end
      wait_drained();
    end

    // A final burst after the sender has paused for a full drain.
    for (int k = 0; k < 80; k++) pending_points.push_back(rand_point());
    wait_drained();
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && flux_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout at cycle %0d", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
